// ----- design/mck_pkg.sv -----
// shared types, character codes and code tables for the morse character keyer
package mck_pkg;

    // element pattern queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // longest element pattern (digits)
    localparam int PAT_W = 5;
    localparam int LEN_W = 3;

    // character codes
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // one classified character, pattern left aligned, 1 = dash
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
        logic             word_gap;
        logic             unknown;
    } mck_desc_t;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } mck_qstat_t;

    // element count of a letter, index 0 = a
    function automatic logic [LEN_W-1:0] letter_len(input logic [4:0] idx);
        logic [LEN_W-1:0] r;
        unique case (idx)
            5'd4, 5'd19:                                   r = 3'd1;
            5'd0, 5'd8, 5'd12, 5'd13:                      r = 3'd2;
            5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18,
            5'd20, 5'd22:                                  r = 3'd3;
            default:                                       r = 3'd4;
        endcase
        return r;
    endfunction

    // element bits of a letter, first element in the top used bit
    function automatic logic [3:0] letter_bits(input logic [4:0] idx);
        logic [3:0] r;
        unique case (idx)
            5'd0:  r = 4'h1;
            5'd1:  r = 4'h8;
            5'd2:  r = 4'hA;
            5'd3:  r = 4'h4;
            5'd5:  r = 4'h2;
            5'd6:  r = 4'h6;
            5'd9:  r = 4'h7;
            5'd10: r = 4'h5;
            5'd11: r = 4'h4;
            5'd12: r = 4'h3;
            5'd13: r = 4'h2;
            5'd14: r = 4'h7;
            5'd15: r = 4'h6;
            5'd16: r = 4'hD;
            5'd17: r = 4'h2;
            5'd19: r = 4'h1;
            5'd20: r = 4'h1;
            5'd21: r = 4'h1;
            5'd22: r = 4'h3;
            5'd23: r = 4'h9;
            5'd24: r = 4'hB;
            5'd25: r = 4'hC;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    // element bits of a digit
    function automatic logic [PAT_W-1:0] digit_bits(input logic [3:0] idx);
        logic [PAT_W-1:0] r;
        unique case (idx)
            4'd0: r = 5'd31;
            4'd1: r = 5'd15;
            4'd2: r = 5'd7;
            4'd3: r = 5'd3;
            4'd4: r = 5'd1;
            4'd6: r = 5'd16;
            4'd7: r = 5'd24;
            4'd8: r = 5'd28;
            4'd9: r = 5'd30;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/mck_front.sv -----
// front end: accepts a character word and classifies it into an element pattern
module mck_front (
    input  logic               start,
    input  logic [7:0]         char_code,
    input  logic               q_full,
    output logic               busy,
    output logic               push,
    output mck_pkg::mck_desc_t desc
);
    import mck_pkg::*;

    logic [7:0]       lower;
    logic [7:0]       lidx;
    logic [7:0]       didx;
    logic             is_letter;
    logic             is_digit;
    logic [LEN_W-1:0] raw_len;
    logic [PAT_W-1:0] raw_bits;
    logic [LEN_W-1:0] shamt;

    // word handshake
    assign busy = q_full;
    assign push = start && !q_full;

    // character class
    assign lower     = char_code | CASE_BIT;
    assign lidx      = lower - CH_LOWER_A;
    assign didx      = char_code - CH_DIGIT_0;
    assign is_letter = (lower >= CH_LOWER_A) && (lower <= CH_LOWER_Z);
    assign is_digit  = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);

    // raw pattern lookup
    always_comb
    begin
        raw_len  = '0;
        raw_bits = '0;
        if (is_letter)
        begin
            raw_len  = letter_len(lidx[4:0]);
            raw_bits = {1'b0, letter_bits(lidx[4:0])};
        end
        else if (is_digit)
        begin
            raw_len  = LEN_W'(PAT_W);
            raw_bits = digit_bits(didx[3:0]);
        end
    end

    // left align the pattern so the first element sits in the top bit
    assign shamt = LEN_W'(PAT_W) - raw_len;

    always_comb
    begin
        desc.len      = raw_len;
        desc.pat      = raw_bits << shamt;
        desc.word_gap = !is_letter && !is_digit
                        && ((char_code == CH_DASH) || (char_code == CH_SPACE));
        desc.unknown  = !is_letter && !is_digit
                        && (char_code != CH_DASH) && (char_code != CH_SPACE);
    end

endmodule

// ----- design/mck_queue.sv -----
// short queue of classified characters between front and back end
module mck_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mck_pkg::mck_desc_t wr_data,
    input  logic               pop,
    output mck_pkg::mck_desc_t rd_data,
    output mck_pkg::mck_qstat_t stat
);
    import mck_pkg::*;

    mck_desc_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign rd_data    = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && !stat.empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/mck_back.sv -----
// back end: steps through a character's elements and gaps, one unit slot a cycle
module mck_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mck_pkg::mck_desc_t  q_data,
    input  mck_pkg::mck_qstat_t q_stat,
    output logic                pop,
    output logic                strobe,
    output logic                key_level,
    output logic                unknown_char,
    output logic                last_unit
);
    import mck_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MARK  = 3'd1;
    localparam logic [2:0] ST_SPACE = 3'd2;
    localparam logic [2:0] ST_WGAP  = 3'd3;
    localparam logic [2:0] ST_LGAP  = 3'd4;

    localparam logic [1:0] DASH_LEFT = 2'd2;
    localparam logic [1:0] GAP_LEFT  = 2'd2;

    logic [2:0]       st_reg, st_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic             wg_reg, wg_next;
    logic             unk_reg, unk_next;

    logic             strobe_reg, strobe_next;
    logic             key_reg, key_next;
    logic             ukn_reg, ukn_next;
    logic             last_reg, last_next;

    logic [2:0]       ld_st;
    logic [1:0]       ld_cnt;

    // first state of a queued character
    always_comb
    begin
        if (q_data.len != '0)
        begin
            ld_st  = ST_MARK;
            ld_cnt = q_data.pat[PAT_W-1] ? DASH_LEFT : 2'd0;
        end
        else if (q_data.word_gap)
        begin
            ld_st  = ST_WGAP;
            ld_cnt = 2'd0;
        end
        else
        begin
            ld_st  = ST_LGAP;
            ld_cnt = GAP_LEFT;
        end
    end

    // slot sequencer
    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        pat_next = pat_reg;
        wg_next  = wg_reg;
        unk_next = unk_reg;
        pop      = 1'b0;

        strobe_next = (st_reg != ST_IDLE);
        key_next    = (st_reg == ST_MARK);
        ukn_next    = (st_reg == ST_LGAP) && unk_reg;
        last_next   = (st_reg == ST_LGAP) && (cnt_reg == 2'd0);

        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    st_next  = ld_st;
                    cnt_next = ld_cnt;
                    rem_next = q_data.len - 1'b1;
                    pat_next = q_data.pat;
                    wg_next  = q_data.word_gap;
                    unk_next = q_data.unknown;
                end
            end
            ST_MARK:
            begin
                if (cnt_reg != 2'd0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (rem_reg != '0)
                begin
                    st_next = ST_SPACE;
                end
                else if (wg_reg)
                begin
                    st_next = ST_WGAP;
                end
                else
                begin
                    st_next  = ST_LGAP;
                    cnt_next = GAP_LEFT;
                end
            end
            ST_SPACE:
            begin
                st_next  = ST_MARK;
                cnt_next = pat_reg[PAT_W-2] ? DASH_LEFT : 2'd0;
                pat_next = pat_reg << 1;
                rem_next = rem_reg - 1'b1;
            end
            ST_WGAP:
            begin
                st_next  = ST_LGAP;
                cnt_next = GAP_LEFT;
            end
            ST_LGAP:
            begin
                if (cnt_reg != 2'd0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    st_next  = ld_st;
                    cnt_next = ld_cnt;
                    rem_next = q_data.len - 1'b1;
                    pat_next = q_data.pat;
                    wg_next  = q_data.word_gap;
                    unk_next = q_data.unknown;
                end
                else
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            strobe_reg <= strobe_next;
        end
    end

    // working and slot payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        pat_reg  <= pat_next;
        wg_reg   <= wg_next;
        unk_reg  <= unk_next;
        key_reg  <= key_next;
        ukn_reg  <= ukn_next;
        last_reg <= last_next;
    end

    assign strobe       = strobe_reg;
    assign key_level    = key_reg;
    assign unknown_char = ukn_reg;
    assign last_unit    = last_reg;

endmodule

// ----- design/morse_character_keyer.sv -----
// top level of the morse character keyer
//
// Usage: present an ASCII code on char_code with start high; the word is taken
// at a rising edge where busy is low. The block answers with a run of dot-unit
// slots, one per clock, each shown for one cycle with strobe high and carrying
// key_level, unknown_char and last_unit (high on the final slot of the run).
// Letters of either case and digits key their code, dash and space give four
// low slots, anything else gives three low slots with unknown_char set.
// The first slot of a character taken while the keyer is idle passes through
// the queue, the sequencer state register and the registered slot outputs.
// A character runs for 3 to 22 slots (22 for the digit zero); consecutive
// characters run back to back with no idle slot between them when the next
// word is already queued as the final slot of the previous run is set up.
// A two-entry queue between the classifier and the sequencer lets new words
// be taken while earlier ones still key; busy is high while it is full.
// Reset clears the queue and the sequencer; no slot is shown until a word
// is taken. The receiver cannot stall: each slot is valid for one cycle only.
module morse_character_keyer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] char_code,
    output logic       strobe,
    output logic       key_level,
    output logic       unknown_char,
    output logic       last_unit
);
    import mck_pkg::*;

    mck_desc_t  wr_desc;
    mck_desc_t  rd_desc;
    mck_qstat_t q_stat;
    logic       push;
    logic       pop;

    // classify incoming words
    mck_front u_front (
        .start     (start),
        .char_code (char_code),
        .q_full    (q_stat.full),
        .busy      (busy),
        .push      (push),
        .desc      (wr_desc)
    );

    // decoupling queue
    mck_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_desc),
        .pop     (pop),
        .rd_data (rd_desc),
        .stat    (q_stat)
    );

    // slot sequencer
    mck_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (rd_desc),
        .q_stat       (q_stat),
        .pop          (pop),
        .strobe       (strobe),
        .key_level    (key_level),
        .unknown_char (unknown_char),
        .last_unit    (last_unit)
    );

endmodule

// ----- design/mck_checker.sv -----
// port level checks for the morse character keyer and their bind
module mck_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic       key_level,
    input logic       unknown_char,
    input logic       last_unit
);

    // the final slot of a run is always a gap slot
    a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_unit |-> !key_level)
        else $error("last slot of a run is keyed");

    // a keyed slot is never final, so another slot follows at once
    a_mark_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && key_level |=> strobe && !last_unit || strobe && !key_level)
        else $error("run broken after a keyed slot");

    // an unknown character keeps its flag until its final slot
    a_unknown_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && unknown_char && !last_unit |=> strobe && unknown_char && !key_level)
        else $error("unknown character run broken");

    // an unknown character is never keyed
    a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(key_level && unknown_char))
        else $error("keyed slot flagged unknown");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .strobe       (strobe),
    .key_level    (key_level),
    .unknown_char (unknown_char),
    .last_unit    (last_unit)
);

// ----- test/tb_morse_character_keyer.sv -----
// self-checking testbench for the morse character keyer
`timescale 1ns / 1ps

module tb_morse_character_keyer;

    import mck_pkg::*;

    // one dot-unit slot as seen on the result ports
    typedef struct {
        logic key;
        logic unk;
        logic last;
    } keyer_slot_t;

    // predicts the slot run of each taken word and checks the slots that come out
    class keyer_scoreboard;
        keyer_slot_t pending_slots[$];
        int          errors;
        int unsigned letter_len[26];
        int unsigned letter_pat[26];
        int unsigned digit_pat[10];

        function new();
            errors     = 0;
            letter_len = '{2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2,
                           2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4};
            letter_pat = '{4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0,
                           4'h7, 4'h5, 4'h4, 4'h3, 4'h2, 4'h7, 4'h6, 4'hD, 4'h2,
                           4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC};
            digit_pat  = '{31, 15, 7, 3, 1, 0, 16, 24, 28, 30};
        endfunction

        function void push_slot(logic key, logic unk, logic last);
            keyer_slot_t s;
            s.key  = key;
            s.unk  = unk;
            s.last = last;
            pending_slots.push_back(s);
        endfunction

        // work out the slot run of one accepted character
        function void note_char(logic [7:0] code);
            logic [7:0]  folded;
            int unsigned elem_cnt;
            int unsigned pat;
            logic        word_gap;
            logic        unk;
            int unsigned run;
            folded   = code | CASE_BIT;
            elem_cnt = 0;
            pat      = 0;
            word_gap = 1'b0;
            unk      = 1'b0;
            if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) begin
                elem_cnt = letter_len[folded - CH_LOWER_A];
                pat      = letter_pat[folded - CH_LOWER_A];
            end
            else if (code >= CH_DIGIT_0 && code <= CH_DIGIT_9) begin
                elem_cnt = 5;
                pat      = digit_pat[code - CH_DIGIT_0];
            end
            else if (code == CH_DASH || code == CH_SPACE) begin
                word_gap = 1'b1;
            end
            else begin
                unk = 1'b1;
            end
            // elements, one low slot between them
            for (int i = 0; i < elem_cnt; i++) begin
                run = ((pat >> (elem_cnt - 1 - i)) & 1) ? 3 : 1;
                if (i != 0)
                    push_slot(1'b0, 1'b0, 1'b0);
                for (int j = 0; j < run; j++)
                    push_slot(1'b1, 1'b0, 1'b0);
            end
            if (word_gap)
                push_slot(1'b0, 1'b0, 1'b0);
            // letter gap closes every run
            for (int i = 0; i < 3; i++)
                push_slot(1'b0, unk, i == 2);
        endfunction

        // compare one slot with the oldest prediction
        function void check_slot(logic key, logic unk, logic last);
            keyer_slot_t s;
            if (pending_slots.size() == 0) begin
                $display("%0t: unexpected slot, expected none, actual key %b unk %b last %b",
                         $time, key, unk, last);
                errors++;
                return;
            end
            s = pending_slots.pop_front();
            if (key !== s.key) begin
                $display("%0t: key_level mismatch, expected %b, actual %b",
                         $time, s.key, key);
                errors++;
            end
            if (unk !== s.unk) begin
                $display("%0t: unknown_char mismatch, expected %b, actual %b",
                         $time, s.unk, unk);
                errors++;
            end
            if (last !== s.last) begin
                $display("%0t: last_unit mismatch, expected %b, actual %b",
                         $time, s.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       busy;
    logic       strobe;
    logic       key_level;
    logic       unknown_char;
    logic       last_unit;

    keyer_scoreboard sb;
    int              idle_pct;

    morse_character_keyer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .char_code    (char_code),
        .strobe       (strobe),
        .key_level    (key_level),
        .unknown_char (unknown_char),
        .last_unit    (last_unit)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_slot(key_level, unknown_char, last_unit);
    end

    // present one word and hold it until taken
    task automatic send_char(input logic [7:0] code);
        start     <= 1'b1;
        char_code <= code;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_char(code);
    endtask

    // random gap on the sender side
    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            char_code <= 8'($urandom_range(255));
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    // mostly keyable characters, some arbitrary codes
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'h41 + 8'($urandom_range(25));
        else if (r < 60)
            return CH_LOWER_A + 8'($urandom_range(25));
        else if (r < 75)
            return CH_DIGIT_0 + 8'($urandom_range(9));
        else if (r < 80)
            return CH_DASH;
        else if (r < 85)
            return CH_SPACE;
        else
            return 8'($urandom_range(255));
    endfunction

    // run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [7:0] directed[$];
        int         phase_pct[4];

        sb        = new();
        idle_pct  = 0;
        phase_pct = '{0, 75, 0, 28};
        directed  = '{8'h41, 8'h61, 8'h5A, 8'h7A, 8'h45, 8'h74, 8'h51, 8'h30,
                      8'h39, 8'h35, CH_DASH, CH_SPACE, 8'h00, 8'hFF, 8'h80, 8'hC1,
                      8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h7F, 8'h30};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, back to back
        foreach (directed[i])
            send_char(directed[i]);

        // random words in phases of sender idling
        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            repeat (60)
            begin
                maybe_idle();
                send_char(pick_char());
            end
        end
        start <= 1'b0;

        // drain
        while (sb.pending_slots.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
